>>> hdl/socd_pkg.sv
// ----------------------------------------------------------------------------
// socd_pkg: shared types and constants for the SOCD key cleaner
// Group layout, state codes, result and control structs, slot code helper.
// ----------------------------------------------------------------------------
package socd_pkg;

  localparam int NUM_GROUPS     = 7;
  localparam int KEYS_PER_GROUP = 4;
  localparam int KEY_CODE_BITS  = 10;
  localparam int REG_W          = KEYS_PER_GROUP * KEY_CODE_BITS;

  localparam int GRP_W     = 3;   // group index, depth NUM_GROUPS
  localparam int SLOT_W    = 2;   // slot index, depth KEYS_PER_GROUP
  localparam int CNT_W     = 3;   // list fill count, 0..KEYS_PER_GROUP
  localparam int CFG_IDX_W = 3;
  localparam int TYPE_W    = 16;
  localparam int CODE_W    = 16;
  localparam int VALUE_W   = 32;

  localparam logic [TYPE_W-1:0] EV_KEY = 16'd1;

  typedef logic [KEY_CODE_BITS-1:0] key_code_t;
  typedef logic [REG_W-1:0]         key_row_t;
  typedef logic [GRP_W-1:0]         grp_t;
  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // Default groups: A/D, W/S, LEFT/RIGHT, UP/DOWN, two letter pairs,
  // keypad 4/5/6/8.
  localparam key_row_t KEYS_RESET [NUM_GROUPS] = '{
    40'd32798, 40'd31761, 40'd108649, 40'd110695,
    40'd38947, 40'd37924, 40'd558889440772
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_GROUP,
    S_SLOT,
    S_PASS,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [TYPE_W-1:0]         typ;
    logic [CODE_W-1:0]         code;
    logic signed [VALUE_W-1:0] value;
  } result_t;

  typedef struct packed {
    logic  upd;       // apply press/release to the group list
    logic  pressed;
    slot_t slot;
    logic  fwr;       // write one forced-down bit
    slot_t fidx;
    logic  fval;
  } list_cmd_t;

  typedef struct packed {
    cnt_t                      upd_count;  // count after this cycle's update
    slot_t                     newest;
    logic [KEYS_PER_GROUP-1:0] forced;
  } list_sts_t;

  typedef struct packed {
    logic push;
    logic flush;
  } buf_ctl_t;

  typedef struct packed {
    logic room;
    logic held_valid;
  } buf_sts_t;

  function automatic key_code_t slot_code(key_row_t row, slot_t s);
    return row[s*KEY_CODE_BITS +: KEY_CODE_BITS];
  endfunction

endpackage

>>> hdl/socd_match.sv
// ----------------------------------------------------------------------------
// socd_match: shared key code matcher
// Finds the first slot of a group whose code equals the probe code.
// ----------------------------------------------------------------------------
module socd_match (
  input  socd_pkg::key_row_t            keys,
  input  logic [socd_pkg::CODE_W-1:0]   probe,
  output logic                          hit,
  output socd_pkg::slot_t               slot
);

  // walk downward so the lowest matching slot wins
  always_comb begin
    hit  = 1'b0;
    slot = '0;
    for (int i = socd_pkg::KEYS_PER_GROUP - 1; i >= 0; i--) begin
      if (socd_pkg::CODE_W'(socd_pkg::slot_code(keys, socd_pkg::SLOT_W'(i))) == probe) begin
        hit  = 1'b1;
        slot = socd_pkg::SLOT_W'(i);
      end
    end
  end

endmodule

>>> hdl/socd_list.sv
// ----------------------------------------------------------------------------
// socd_list: per-group press-order lists and forced-down bits
// One group row is read and updated per cycle, selected by grp.
// ----------------------------------------------------------------------------
module socd_list (
  input  logic                 clk,
  input  logic                 rst,
  input  socd_pkg::grp_t       grp,
  input  socd_pkg::list_cmd_t  cmd,
  output socd_pkg::list_sts_t  sts
);

  socd_pkg::slot_t order [socd_pkg::NUM_GROUPS][socd_pkg::KEYS_PER_GROUP];
  socd_pkg::cnt_t  count [socd_pkg::NUM_GROUPS];
  logic [socd_pkg::KEYS_PER_GROUP-1:0] forced [socd_pkg::NUM_GROUPS];

  socd_pkg::slot_t row_next [socd_pkg::KEYS_PER_GROUP];
  socd_pkg::cnt_t  cnt_cur;
  socd_pkg::cnt_t  cnt_next;
  socd_pkg::cnt_t  cnt_m1;
  socd_pkg::slot_t at;
  logic            found;

  always_comb begin
    cnt_cur = count[grp];
    cnt_m1  = socd_pkg::CNT_W'(cnt_cur - 1'b1);
    found   = 1'b0;
    at      = '0;
    for (int i = socd_pkg::KEYS_PER_GROUP - 1; i >= 0; i--) begin
      if (socd_pkg::CNT_W'(i) < cnt_cur && order[grp][i] == cmd.slot) begin
        found = 1'b1;
        at    = socd_pkg::SLOT_W'(i);
      end
    end
    row_next = order[grp];
    cnt_next = cnt_cur;
    if (cmd.pressed) begin
      // append if absent; a full list ignores it
      if (!found && cnt_cur < socd_pkg::CNT_W'(socd_pkg::KEYS_PER_GROUP)) begin
        row_next[cnt_cur[socd_pkg::SLOT_W-1:0]] = cmd.slot;
        cnt_next = socd_pkg::CNT_W'(cnt_cur + 1'b1);
      end
    end else if (found) begin
      // close the gap; entries past the count are don't-care
      for (int i = 0; i < socd_pkg::KEYS_PER_GROUP - 1; i++) begin
        if (socd_pkg::SLOT_W'(i) >= at) begin
          row_next[i] = order[grp][i+1];
        end
      end
      cnt_next = cnt_m1;
    end
  end

  always_comb begin
    sts.upd_count = cmd.upd ? cnt_next : cnt_cur;
    sts.newest    = order[grp][cnt_m1[socd_pkg::SLOT_W-1:0]];
    sts.forced    = forced[grp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < socd_pkg::NUM_GROUPS; g++) begin
        count[g]  <= '0;
        forced[g] <= '0;
      end
    end else begin
      if (cmd.upd) begin
        count[grp] <= cnt_next;
      end
      if (cmd.fwr) begin
        forced[grp][cmd.fidx] <= cmd.fval;
      end
    end
  end

  // list entries are only read below the count
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      order[grp] <= row_next;
    end
  end

endmodule

>>> hdl/socd_out.sv
// ----------------------------------------------------------------------------
// socd_out: result buffer
// Holds the newest result until the next one or the end of the item decides
// its last flag, then moves it into the output register.
// ----------------------------------------------------------------------------
module socd_out (
  input  logic               clk,
  input  logic               rst,
  input  socd_pkg::buf_ctl_t ctl,
  input  socd_pkg::result_t  res,
  output socd_pkg::buf_sts_t sts,
  output logic               out_valid,
  input  logic               out_ready,
  output socd_pkg::result_t  out_res,
  output logic               out_last
);

  logic              held_valid;
  socd_pkg::result_t held;
  logic              out_free;
  logic              room;
  logic              take;
  logic              move;

  always_comb begin
    out_free       = !out_valid || out_ready;
    room           = !held_valid || out_free;
    take           = ctl.push && room;
    move           = held_valid && out_free && (ctl.push || ctl.flush);
    sts.room       = room;
    sts.held_valid = held_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        held_valid <= 1'b1;
      end else if (ctl.flush && out_free) begin
        held_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= res;
    end
    if (move) begin
      out_res  <= held;
      out_last <= ctl.flush;
    end
  end

endmodule

>>> hdl/socd_key_cleaner.sv
// ----------------------------------------------------------------------------
// socd_key_cleaner: SOCD cleaner with last-input priority
// Rewrites key events of opposing-key groups so only the newest held key of a
// group reads as down; all other events pass through.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------
//  cfg      | cfg_we              | cfg_index, cfg_data (group key rows)
//  in       | in_valid / in_ready | ev_type, ev_code, ev_value
//  out      | out_valid/out_ready | out_type, out_code, out_value, last
//
// Sequence: a non-key event goes from idle through a pass step and a flush step.
//   A key event walks one code matcher over the groups and, for each group
//   that acts, over its four slots; a pass step follows when no group acts,
//   and a flush step ends the item.
// Results: one per cycle at most; the newest result waits in a hold stage
//   until the next result or the end of the item sets its last flag.
// Stalls: a full output stage holds the sequencer in place; in_ready is high
//   only between items.
// Reset: control state, list counts, forced bits and key rows return to
//   their defaults; list entries are not cleared.
//
module socd_key_cleaner (
  input  logic                                   clk,
  input  logic                                   rst,

  input  logic                                   cfg_we,
  input  logic [socd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [socd_pkg::REG_W-1:0]             cfg_data,

  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [socd_pkg::TYPE_W-1:0]            ev_type,
  input  logic [socd_pkg::CODE_W-1:0]            ev_code,
  input  logic signed [socd_pkg::VALUE_W-1:0]    ev_value,

  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [socd_pkg::TYPE_W-1:0]            out_type,
  output logic [socd_pkg::CODE_W-1:0]            out_code,
  output logic signed [socd_pkg::VALUE_W-1:0]    out_value,
  output logic                                   last
);

  // key rows, one per group
  socd_pkg::key_row_t keys [socd_pkg::NUM_GROUPS];

  // sequencer
  socd_pkg::state_t state, state_next;
  socd_pkg::grp_t   grp, grp_next;
  socd_pkg::slot_t  slot, slot_next;
  logic             dropped, dropped_next;

  // accepted item
  logic [socd_pkg::TYPE_W-1:0]         item_type;
  logic [socd_pkg::CODE_W-1:0]         item_code;
  logic signed [socd_pkg::VALUE_W-1:0] item_value;
  logic                                item_pressed;

  socd_pkg::key_row_t               row;
  socd_pkg::key_code_t              cur_code;
  socd_pkg::key_code_t              newest_code;
  logic [socd_pkg::CODE_W-1:0]      probe;
  logic                             hit;
  socd_pkg::slot_t                  mslot;
  logic                             is_key;
  logic                             emit_press;
  logic                             emit_rel;
  logic                             emit;
  logic                             last_grp;
  logic                             last_slot;

  socd_pkg::list_cmd_t list_cmd;
  socd_pkg::list_sts_t list_sts;
  socd_pkg::buf_ctl_t  buf_ctl;
  socd_pkg::buf_sts_t  buf_sts;
  socd_pkg::result_t   res;
  socd_pkg::result_t   out_res;

  // --------------------------------------------------------------------------
  // Configuration: writes beyond the group list are dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= socd_pkg::KEYS_RESET;
    end else if (cfg_we && int'(cfg_index) < socd_pkg::NUM_GROUPS) begin
      keys[cfg_index] <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath around the shared matcher
  // --------------------------------------------------------------------------
  always_comb begin
    is_key      = (ev_type == socd_pkg::EV_KEY) && (ev_code != '0);
    row         = keys[grp];
    cur_code    = socd_pkg::slot_code(row, slot);
    newest_code = socd_pkg::slot_code(row, list_sts.newest);
    // group step looks up the event code, slot step looks up the slot's own
    // code to find its representative (first) slot
    probe       = (state == socd_pkg::S_GROUP) ? item_code
                                                : socd_pkg::CODE_W'(cur_code);
    emit_press  = (cur_code != '0) && (cur_code == newest_code);
    emit_rel    = (cur_code != '0) && !emit_press && list_sts.forced[mslot];
    emit        = emit_press || emit_rel;
    last_grp    = grp == socd_pkg::GRP_W'(socd_pkg::NUM_GROUPS - 1);
    last_slot   = slot == socd_pkg::SLOT_W'(socd_pkg::KEYS_PER_GROUP - 1);
  end

  socd_match u_match (
    .keys  (row),
    .probe (probe),
    .hit   (hit),
    .slot  (mslot)
  );

  socd_list u_list (
    .clk (clk),
    .rst (rst),
    .grp (grp),
    .cmd (list_cmd),
    .sts (list_sts)
  );

  socd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl       (buf_ctl),
    .res       (res),
    .sts       (buf_sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .out_last  (last)
  );

  assign out_type  = out_res.typ;
  assign out_code  = out_res.code;
  assign out_value = out_res.value;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next   = state;
    grp_next     = grp;
    slot_next    = slot;
    dropped_next = dropped;
    unique case (state)
      socd_pkg::S_IDLE: begin
        if (in_valid) begin
          grp_next     = '0;
          slot_next    = '0;
          dropped_next = 1'b0;
          state_next   = is_key ? socd_pkg::S_GROUP : socd_pkg::S_PASS;
        end
      end
      socd_pkg::S_GROUP: begin
        if (hit && list_sts.upd_count != '0) begin
          // group holds keys after the update: walk its slots
          dropped_next = 1'b1;
          slot_next    = '0;
          state_next   = socd_pkg::S_SLOT;
        end else if (last_grp) begin
          state_next = dropped ? socd_pkg::S_FLUSH : socd_pkg::S_PASS;
        end else begin
          grp_next = socd_pkg::GRP_W'(grp + 1'b1);
        end
      end
      socd_pkg::S_SLOT: begin
        if (!emit || buf_sts.room) begin
          if (!last_slot) begin
            slot_next = socd_pkg::SLOT_W'(slot + 1'b1);
          end else if (last_grp) begin
            state_next = socd_pkg::S_FLUSH;
          end else begin
            grp_next   = socd_pkg::GRP_W'(grp + 1'b1);
            state_next = socd_pkg::S_GROUP;
          end
        end
      end
      socd_pkg::S_PASS: begin
        if (buf_sts.room) begin
          state_next = socd_pkg::S_FLUSH;
        end
      end
      socd_pkg::S_FLUSH: begin
        if (buf_sts.room) begin
          state_next = socd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = socd_pkg::S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready = (state == socd_pkg::S_IDLE);

    list_cmd.upd     = (state == socd_pkg::S_GROUP) && hit;
    list_cmd.pressed = item_pressed;
    list_cmd.slot    = mslot;
    // forced bit changes only when its result is actually taken
    list_cmd.fwr     = (state == socd_pkg::S_SLOT) && emit && buf_sts.room;
    list_cmd.fidx    = mslot;
    list_cmd.fval    = emit_press;

    buf_ctl.push  = ((state == socd_pkg::S_SLOT) && emit) || (state == socd_pkg::S_PASS);
    buf_ctl.flush = (state == socd_pkg::S_FLUSH);

    if (state == socd_pkg::S_PASS) begin
      res.typ   = item_type;
      res.code  = item_code;
      res.value = item_value;
    end else begin
      res.typ   = socd_pkg::EV_KEY;
      res.code  = socd_pkg::CODE_W'(cur_code);
      res.value = emit_press ? socd_pkg::VALUE_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= socd_pkg::S_IDLE;
      grp     <= '0;
      slot    <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      grp     <= grp_next;
      slot    <= slot_next;
      dropped <= dropped_next;
    end
  end

  // negative values count as releases
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_type    <= ev_type;
      item_code    <= ev_code;
      item_value   <= ev_value;
      item_pressed <= ev_value > 0;
    end
  end

`ifndef NO_ASSERTIONS
  // every result of an item is handed on before the next item starts
  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    state == socd_pkg::S_IDLE |-> !buf_sts.held_valid)
    else $error("held result left over between items");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new transfer taken while an item is in work");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (buf_ctl.push && buf_sts.room) |=> buf_sts.held_valid)
    else $error("pushed result lost");

  // a slot walk only runs on a group whose list is not empty
  a_slot_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == socd_pkg::S_SLOT |-> list_sts.upd_count != '0)
    else $error("slot walk on an empty group");
`endif

endmodule

>>> tb/sv/socd_key_cleaner_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// socd_key_cleaner_test: self-checking testbench for the SOCD key cleaner
// Drives key and non-key events through the valid/ready input, rewrites the
// group key rows between phases, predicts every emitted event with a local
// last-input-priority model and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module socd_key_cleaner_test;

  // Standard input key codes used by the default groups and the code pool.
  localparam logic [15:0] KC_W        = 16'd17;
  localparam logic [15:0] KC_A        = 16'd30;
  localparam logic [15:0] KC_S        = 16'd31;
  localparam logic [15:0] KC_D        = 16'd32;
  localparam logic [15:0] KC_UP       = 16'd103;
  localparam logic [15:0] KC_LEFT     = 16'd105;
  localparam logic [15:0] KC_RIGHT    = 16'd106;
  localparam logic [15:0] KC_DOWN     = 16'd108;
  localparam logic [15:0] KC_PAD4     = 16'd516;
  localparam logic [15:0] KC_PAD5     = 16'd517;
  localparam logic [15:0] KC_PAD6     = 16'd518;
  localparam logic [15:0] KC_PAD8     = 16'd520;
  localparam logic [15:0] KC_UNMAPPED = 16'd500;

  // Drain time, sized to outlast the worst key event (every group acting) plus the
  // output stages. Used as the quiet time before a key row write and at the end.
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 60;
  localparam int NUM_DIRECTED   = 24;

  typedef enum logic [socd_pkg::CFG_IDX_W-1:0] {
    REG_GROUP0_KEYS, REG_GROUP1_KEYS, REG_GROUP2_KEYS, REG_GROUP3_KEYS,
    REG_GROUP4_KEYS, REG_GROUP5_KEYS, REG_GROUP6_KEYS, REG_UNUSED
  } key_reg_e;

  typedef enum {CFG_MIXED, CFG_ALL_ONES, CFG_ALL_ZERO, CFG_DEFAULT} row_mode_e;

  // How a directed row is checked: through the predictor, or against a
  // hand-written single result (the event itself, or a forced press).
  typedef enum {BY_MODEL, AS_PASS, AS_PRESS} row_check_e;

  typedef struct packed {
    logic [socd_pkg::TYPE_W-1:0]  typ;
    logic [socd_pkg::CODE_W-1:0]  code;
    logic [socd_pkg::VALUE_W-1:0] value;
    logic                         last;
  } key_event_t;

  typedef struct packed {
    logic [socd_pkg::TYPE_W-1:0]  typ;
    logic [socd_pkg::CODE_W-1:0]  code;
    logic [socd_pkg::VALUE_W-1:0] value;
    row_check_e                   check;
  } stim_row_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_we;
  logic [socd_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [socd_pkg::REG_W-1:0]          cfg_data;
  logic                                in_valid;
  logic                                in_ready;
  logic [socd_pkg::TYPE_W-1:0]         ev_type;
  logic [socd_pkg::CODE_W-1:0]         ev_code;
  logic signed [socd_pkg::VALUE_W-1:0] ev_value;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [socd_pkg::TYPE_W-1:0]         out_type;
  logic [socd_pkg::CODE_W-1:0]         out_code;
  logic signed [socd_pkg::VALUE_W-1:0] out_value;
  logic                                last;

  // Local copy of the block state for prediction.
  socd_pkg::key_row_t key_rows   [socd_pkg::NUM_GROUPS];
  socd_pkg::slot_t    held_order [socd_pkg::NUM_GROUPS][socd_pkg::KEYS_PER_GROUP];
  int                 held_count [socd_pkg::NUM_GROUPS];
  bit                 forced     [socd_pkg::NUM_GROUPS][socd_pkg::KEYS_PER_GROUP];

  key_event_t pending_events[$];   // events the block still owes, oldest first
  key_event_t head_event;
  int         errors = 0;
  int         quiet_cycles = 0;
  bit         steady_flow = 1'b0;  // no input gaps and no output stalls

  // Directed rows run on the reset key rows: A/D, W/S, LEFT/RIGHT, UP/DOWN,
  // two letter pairs and the keypad group 4/5/6/8.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{16'h0000, 16'h0000, 32'h0000_0000, AS_PASS},
    '{16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, AS_PASS},
    '{16'h0002, KC_A,     32'h0000_0001, AS_PASS},   // not a key event
    '{socd_pkg::EV_KEY, 16'h0000, 32'h0000_0001, AS_PASS},  // code zero never matches
    '{socd_pkg::EV_KEY, 16'hFC1E, 32'h0000_0001, AS_PASS},  // A plus high bits
    '{socd_pkg::EV_KEY, KC_UNMAPPED, 32'h8000_0000, AS_PASS},
    '{socd_pkg::EV_KEY, KC_DOWN,  32'h0000_0000, AS_PASS},  // release of a free key
    '{socd_pkg::EV_KEY, KC_A,     32'h0000_0001, AS_PRESS},
    '{socd_pkg::EV_KEY, KC_D,     32'h0000_0001, BY_MODEL}, // D wins, A let go
    '{socd_pkg::EV_KEY, KC_D,     32'h0000_0000, BY_MODEL}, // A back down
    '{socd_pkg::EV_KEY, KC_A,     32'h0000_0002, BY_MODEL}, // repeat
    '{socd_pkg::EV_KEY, KC_A,     32'hFFFF_FFFF, AS_PASS},  // negative is a release
    '{socd_pkg::EV_KEY, KC_W,     32'h0000_0001, AS_PRESS},
    '{socd_pkg::EV_KEY, KC_S,     32'h7FFF_FFFF, BY_MODEL},
    '{socd_pkg::EV_KEY, KC_W,     32'h0000_0000, BY_MODEL},
    '{socd_pkg::EV_KEY, KC_S,     32'h8000_0000, AS_PASS},
    '{socd_pkg::EV_KEY, KC_PAD4,  32'h0000_0001, AS_PRESS},
    '{socd_pkg::EV_KEY, KC_PAD5,  32'h0000_0001, BY_MODEL},
    '{socd_pkg::EV_KEY, KC_PAD6,  32'h0000_0001, BY_MODEL},
    '{socd_pkg::EV_KEY, KC_PAD8,  32'h0000_0001, BY_MODEL}, // list now full
    '{socd_pkg::EV_KEY, KC_PAD5,  32'h0000_0000, BY_MODEL}, // middle removal
    '{socd_pkg::EV_KEY, KC_LEFT,  32'h0000_0001, AS_PRESS},
    '{socd_pkg::EV_KEY, KC_RIGHT, 32'h0000_0001, BY_MODEL},
    '{socd_pkg::EV_KEY, KC_UP,    32'h0000_0001, AS_PRESS}
  };

  socd_key_cleaner u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ev_type   (ev_type),
    .ev_code   (ev_code),
    .ev_value  (ev_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_type  (out_type),
    .out_code  (out_code),
    .out_value (out_value),
    .last      (last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic socd_pkg::key_code_t code_at(int g, int s);
    return key_rows[g][s*socd_pkg::KEY_CODE_BITS +: socd_pkg::KEY_CODE_BITS];
  endfunction

  // First slot of group g holding this code; KEYS_PER_GROUP when none does.
  // The full 16-bit code is compared, so high bits defeat a match.
  function automatic int first_slot(int g, logic [socd_pkg::CODE_W-1:0] code);
    int s;
    for (s = 0; s < socd_pkg::KEYS_PER_GROUP; s++)
      if (socd_pkg::CODE_W'(code_at(g, s)) == code)
        return s;
    return socd_pkg::KEYS_PER_GROUP;
  endfunction

  // Walks the groups for one accepted event, updates the held lists and
  // forced bits, and queues the emitted events when keep is set.
  task automatic predict_events(input logic [socd_pkg::TYPE_W-1:0] t,
                                input logic [socd_pkg::CODE_W-1:0] c,
                                input logic [socd_pkg::VALUE_W-1:0] v, input bit keep);
    key_event_t         produced[$];
    bit                 pressed;
    bit                 dropped;
    int                 g, s, i, slot, at, cnt, k;
    socd_pkg::key_code_t newest, kc;
    pressed = (v != '0) && !v[socd_pkg::VALUE_W-1];
    dropped = 1'b0;
    if (t == socd_pkg::EV_KEY && c != '0) begin
      for (g = 0; g < socd_pkg::NUM_GROUPS; g++) begin
        slot = first_slot(g, c);
        if (slot == socd_pkg::KEYS_PER_GROUP)
          continue;
        cnt = held_count[g];
        at  = socd_pkg::KEYS_PER_GROUP;
        for (i = 0; i < cnt; i++)
          if (held_order[g][i] == slot) begin
            at = i;
            break;
          end
        if (pressed) begin
          // a key already in the list or a full list leaves it as is
          if (at == socd_pkg::KEYS_PER_GROUP && cnt < socd_pkg::KEYS_PER_GROUP) begin
            held_order[g][cnt] = socd_pkg::slot_t'(slot);
            held_count[g] = cnt + 1;
          end
        end else if (at != socd_pkg::KEYS_PER_GROUP) begin
          for (i = at; i + 1 < cnt; i++)
            held_order[g][i] = held_order[g][i+1];
          held_count[g] = cnt - 1;
        end
        if (held_count[g] == 0)
          continue;
        // newest slot may hold code 0 after a row rewrite: releases only
        newest = code_at(g, held_order[g][held_count[g]-1]);
        for (s = 0; s < socd_pkg::KEYS_PER_GROUP; s++) begin
          kc = code_at(g, s);
          if (kc == '0)
            continue;
          k = first_slot(g, socd_pkg::CODE_W'(kc));
          if (kc == newest) begin
            produced.push_back('{socd_pkg::EV_KEY, socd_pkg::CODE_W'(kc),
                                 socd_pkg::VALUE_W'(1), 1'b0});
            forced[g][k] = 1'b1;
          end else if (forced[g][k]) begin
            produced.push_back('{socd_pkg::EV_KEY, socd_pkg::CODE_W'(kc),
                                 socd_pkg::VALUE_W'(0), 1'b0});
            forced[g][k] = 1'b0;
          end
        end
        dropped = 1'b1;
      end
    end
    if (!dropped)
      produced.push_back('{t, c, v, 1'b0});
    if (produced.size() > 0)
      produced[produced.size()-1].last = 1'b1;
    if (keep)
      foreach (produced[i])
        pending_events.push_back(produced[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One input transfer. Valid stays up between back-to-back events; an
  // occasional gap drops it first, unless steady flow is set.
  task automatic send_event(input logic [socd_pkg::TYPE_W-1:0] t,
                            input logic [socd_pkg::CODE_W-1:0] c,
                            input logic [socd_pkg::VALUE_W-1:0] v, input bit keep);
    if (!steady_flow && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    ev_type  <= t;
    ev_code  <= c;
    ev_value <= v;
    do @(posedge clk); while (!in_ready);
    predict_events(t, c, v, keep);
  endtask

  // Drop valid and let the block finish: every owed event out, then enough
  // cycles for an event that emits nothing.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_reg(input key_reg_e idx, input socd_pkg::key_row_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (int'(idx) < socd_pkg::NUM_GROUPS)
      key_rows[idx] = data;
  endtask

  // Slot codes drawn from a small pool so that groups overlap and repeat codes.
  function automatic socd_pkg::key_code_t pick_row_code();
    case ($urandom_range(11))
      0, 1:    return '0;
      2:       return socd_pkg::key_code_t'($urandom_range(1, 1023));
      3:       return socd_pkg::key_code_t'(KC_A);
      4:       return socd_pkg::key_code_t'(KC_D);
      5:       return socd_pkg::key_code_t'(KC_W);
      6:       return socd_pkg::key_code_t'(KC_S);
      7:       return socd_pkg::key_code_t'(KC_LEFT);
      8:       return socd_pkg::key_code_t'(KC_RIGHT);
      9:       return socd_pkg::key_code_t'(KC_PAD4);
      10:      return socd_pkg::key_code_t'(KC_PAD8);
      default: return '1;
    endcase
  endfunction

  task automatic configure_groups(input row_mode_e mode);
    socd_pkg::key_row_t row;
    int                 g, s;
    for (g = 0; g < socd_pkg::NUM_GROUPS; g++) begin
      case (mode)
        CFG_ALL_ONES: row = '1;
        CFG_ALL_ZERO: row = '0;
        CFG_DEFAULT:  row = socd_pkg::KEYS_RESET[g];
        default: begin
          if ($urandom_range(6) == 0)
            row = socd_pkg::key_row_t'({$urandom, $urandom});
          else
            for (s = 0; s < socd_pkg::KEYS_PER_GROUP; s++)
              row[s*socd_pkg::KEY_CODE_BITS +: socd_pkg::KEY_CODE_BITS] = pick_row_code();
        end
      endcase
      write_key_reg(key_reg_e'(g), row);
    end
    // the spare index is not a register and must change nothing
    if (mode == CFG_MIXED)
      write_key_reg(REG_UNUSED, socd_pkg::key_row_t'({$urandom, $urandom}));
    cfg_we <= 1'b0;
  endtask

  // A code currently configured somewhere, now and then with the unused high
  // bits set so that it must not match.
  function automatic logic [socd_pkg::CODE_W-1:0] pick_key_code();
    socd_pkg::key_code_t         kc;
    logic [socd_pkg::CODE_W-1:0] code;
    int                          tries;
    kc = '0;
    for (tries = 0; tries < 8 && kc == '0; tries++)
      kc = code_at($urandom_range(socd_pkg::NUM_GROUPS-1),
                   $urandom_range(socd_pkg::KEYS_PER_GROUP-1));
    if (kc == '0)
      kc = socd_pkg::key_code_t'($urandom_range(1, 1023));
    code = socd_pkg::CODE_W'(kc);
    if ($urandom_range(19) == 0)
      code[socd_pkg::CODE_W-1:socd_pkg::KEY_CODE_BITS] =
        (socd_pkg::CODE_W-socd_pkg::KEY_CODE_BITS)'($urandom);
    return code;
  endfunction

  function automatic logic [socd_pkg::VALUE_W-1:0] pick_key_value();
    int r;
    r = $urandom_range(99);
    if (r < 45)      return socd_pkg::VALUE_W'(1);
    else if (r < 80) return '0;
    else if (r < 88) return {1'b0, 31'($urandom)};
    else if (r < 95) return {1'b1, 31'($urandom)};
    else if (r < 97) return 32'h7FFF_FFFF;
    else             return 32'h8000_0000;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls, with a stall-free stretch in the steady phase.
  // ---------------------------------------------------------------------------
  always @(posedge clk)
    out_ready <= steady_flow || ($urandom_range(99) >= 9);

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Every output transfer is matched against the oldest owed event.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: transfer with none owed, expected nothing actual %h %h %h %b",
                 $time, out_type, out_code, out_value, last);
        errors++;
      end else begin
        head_event = pending_events.pop_front();
        compare_field("out_type", 32'(head_event.typ), 32'(out_type));
        compare_field("out_code", 32'(head_event.code), 32'(out_code));
        compare_field("out_value", head_event.value, out_value);
        compare_field("last", 32'(head_event.last), 32'(last));
      end
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                          p, n, r, g, s;
    stim_row_t                   row;
    logic [socd_pkg::CODE_W-1:0] code;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    ev_type   = '0;
    ev_code   = '0;
    ev_value  = '0;
    for (g = 0; g < socd_pkg::NUM_GROUPS; g++) begin
      key_rows[g]   = socd_pkg::KEYS_RESET[g];
      held_count[g] = 0;
      for (s = 0; s < socd_pkg::KEYS_PER_GROUP; s++)
        forced[g][s] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset key rows. Rows with a hand-written result
    // still run through the predictor to keep its state in step.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_event(row.typ, row.code, row.value, row.check == BY_MODEL);
      case (row.check)
        AS_PASS:  pending_events.push_back('{row.typ, row.code, row.value, 1'b1});
        AS_PRESS: pending_events.push_back('{socd_pkg::EV_KEY, row.code,
                                             socd_pkg::VALUE_W'(1), 1'b1});
        default: ;
      endcase
    end

    // Random phases. Held lists and forced bits carry over each row rewrite,
    // so stale slots, shared keys and repeated codes all come up.
    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        1:       configure_groups(CFG_ALL_ONES);   // one key in every slot
        3:       configure_groups(CFG_DEFAULT);
        4:       configure_groups(CFG_ALL_ZERO);   // nothing matches
        default: configure_groups(CFG_MIXED);
      endcase
      steady_flow = (p == 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 75) begin
          send_event(socd_pkg::EV_KEY, pick_key_code(), pick_key_value(), 1'b1);
        end else if (r < 85) begin
          code = socd_pkg::CODE_W'($urandom);
          send_event(socd_pkg::EV_KEY, code, pick_key_value(), 1'b1);
        end else begin
          send_event(socd_pkg::TYPE_W'($urandom), socd_pkg::CODE_W'($urandom),
                     $urandom, 1'b1);
        end
      end
    end

    steady_flow = 1'b0;
    wait_drained();
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> socd_key_cleaner.f
hdl/socd_pkg.sv
hdl/socd_match.sv
hdl/socd_list.sv
hdl/socd_out.sv
hdl/socd_key_cleaner.sv
tb/sv/socd_key_cleaner_test.sv
